>>> hdl/entity_id_allocator_with_signatures_unit_macros.svh
// Assertion macros shared by the allocator modules.
// No dependencies; included by the controller and the datapath.
`ifndef ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_UNIT_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define EIDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define EIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/eida_pkg.sv
// Types, codes and defaults for the entity ID allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package eida_pkg;

    // Default configuration
    localparam int ENTITY_SLOTS_DEF   = 4096;
    localparam int SIGNATURE_BITS_DEF = 32;

    // Request codes
    typedef enum logic [1:0] {
        FN_CREATE  = 2'd0,
        FN_DESTROY = 2'd1,
        FN_SET_SIG = 2'd2,
        FN_GET_SIG = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Input word
    typedef struct packed {
        t_func       func;
        logic [11:0] entity_id;
        logic [31:0] signature_in;
    } t_req;

    // Result word
    typedef struct packed {
        t_status     status;
        logic [11:0] entity_out;
        logic [31:0] signature_out;
        logic [12:0] living_count;
    } t_rsp;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic exec;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/eida_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module eida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/eida_ctrl.sv
// Controller of the allocator: clearing pass, accept and execute sequencing.
// Depends on eida_pkg and the assertion macro header.
`default_nettype none

`include "entity_id_allocator_with_signatures_unit_macros.svh"

module eida_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire eida_pkg::t_dp_stat i_stat,
    output eida_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);

    eida_pkg::t_state r_state;
    eida_pkg::t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eida_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance state and drive commands
    always_comb begin
        n_state        = r_state;
        o_cmd.clear_wr = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_busy         = 1'b1;
        case (r_state)
            eida_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = eida_pkg::S_IDLE;
                end
            end
            eida_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = eida_pkg::S_EXEC;
                end
            end
            eida_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = eida_pkg::S_IDLE;
            end
            default: begin
                n_state = eida_pkg::S_CLEAR;
            end
        endcase
    end

    `EIDA_ASSERT_SAME(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "commands overlap")
    `EIDA_ASSERT_NEXT(a_load_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec, "load not followed by exec")
    `EIDA_ASSERT_NEXT(a_exec_idle, i_clk, i_rst_n, o_cmd.exec, !o_busy, "exec not followed by idle")

endmodule

`default_nettype wire

>>> hdl/eida_dp.sv
// Datapath of the allocator: free-ID queue, signature table, counters, result.
// Depends on eida_pkg, eida_ram and the assertion macro header.
`default_nettype none

`include "entity_id_allocator_with_signatures_unit_macros.svh"

module eida_dp #(
    parameter int ENTITY_SLOTS   = eida_pkg::ENTITY_SLOTS_DEF,
    parameter int SIGNATURE_BITS = eida_pkg::SIGNATURE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire eida_pkg::t_dp_cmd i_cmd,
    input  wire eida_pkg::t_req    i_req,
    output eida_pkg::t_dp_stat     o_stat,
    output eida_pkg::t_rsp         o_rsp,
    output logic                   o_done
);

    localparam int IW = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
    localparam int CW = $clog2(ENTITY_SLOTS + 1);
    localparam int SB = SIGNATURE_BITS;

    // Control state
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_tail_wrap, n_tail_wrap;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_clr;
    logic          r_done;

    // Payload
    eida_pkg::t_req r_req;
    eida_pkg::t_rsp r_rsp, n_rsp;

    // Memory ports
    logic          q_we;
    logic [IW-1:0] q_rdata;
    logic          s_we;
    logic [IW-1:0] s_waddr;
    logic [SB-1:0] s_wdata;
    logic [SB-1:0] s_rdata;

    logic          id_valid;
    logic          q_fresh;
    logic [IW-1:0] alloc_id;
    logic [IW-1:0] req_idx;

    // Free-ID queue; slots not yet written read as their own index
    eida_ram #(.WIDTH(IW), .DEPTH(ENTITY_SLOTS)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (req_idx),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // Signature table, zeroed by the clearing pass
    eida_ram #(.WIDTH(SB), .DEPTH(ENTITY_SLOTS)) u_sig (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (IW'(i_req.entity_id)),
        .o_rdata (s_rdata)
    );

    assign req_idx  = IW'(r_req.entity_id);
    assign id_valid = 32'(r_req.entity_id) < 32'(ENTITY_SLOTS);
    assign q_fresh  = r_tail_wrap || (r_head < r_tail);
    assign alloc_id = q_fresh ? q_rdata : r_head;

    assign o_stat.clear_last = (r_clr == IW'(ENTITY_SLOTS - 1));

    // Drive the clearing-pass write and execute the latched request against the read data
    always_comb begin
        n_head            = r_head;
        n_tail            = r_tail;
        n_tail_wrap       = r_tail_wrap;
        n_count           = r_count;
        q_we              = 1'b0;
        s_we              = 1'b0;
        s_waddr           = req_idx;
        s_wdata           = '0;
        n_rsp.status      = eida_pkg::ST_OK;
        n_rsp.entity_out  = r_req.entity_id;
        n_rsp.signature_out = '0;
        if (i_cmd.clear_wr) begin
            s_we    = 1'b1;
            s_waddr = r_clr;
        end
        if (i_cmd.exec) begin
            case (r_req.func)
                eida_pkg::FN_CREATE: begin
                    if (r_count == CW'(ENTITY_SLOTS)) begin
                        n_rsp.status     = eida_pkg::ST_FULL;
                        n_rsp.entity_out = '0;
                    end else begin
                        n_rsp.entity_out = 12'(alloc_id);
                        n_head  = (r_head == IW'(ENTITY_SLOTS - 1)) ? '0 : r_head + IW'(1);
                        n_count = r_count + CW'(1);
                    end
                end
                eida_pkg::FN_DESTROY: begin
                    if (!id_valid) begin
                        n_rsp.status = eida_pkg::ST_INVALID;
                    end else begin
                        s_we = 1'b1;
                        if (r_count != '0) begin
                            q_we    = 1'b1;
                            n_count = r_count - CW'(1);
                            if (r_tail == IW'(ENTITY_SLOTS - 1)) begin
                                n_tail      = '0;
                                n_tail_wrap = 1'b1;
                            end else begin
                                n_tail = r_tail + IW'(1);
                            end
                        end
                    end
                end
                eida_pkg::FN_SET_SIG: begin
                    if (!id_valid) begin
                        n_rsp.status = eida_pkg::ST_INVALID;
                    end else begin
                        s_we    = 1'b1;
                        s_wdata = SB'(r_req.signature_in);
                    end
                end
                eida_pkg::FN_GET_SIG: begin
                    if (!id_valid) begin
                        n_rsp.status = eida_pkg::ST_INVALID;
                    end else begin
                        n_rsp.signature_out = 32'(s_rdata);
                    end
                end
                default: begin
                    n_rsp.status = eida_pkg::ST_INVALID;
                end
            endcase
        end
        n_rsp.living_count = 13'(n_count);
    end

    // Hold queue pointers, count, clear address and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_tail_wrap <= 1'b0;
            r_count     <= '0;
            r_clr       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_tail_wrap <= n_tail_wrap;
            r_count     <= n_count;
            r_done      <= i_cmd.exec;
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + IW'(1);
            end
        end
    end

    // Capture request and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

    `EIDA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done, "strobe held two cycles")
    `EIDA_ASSERT_SAME(a_full_count, i_clk, i_rst_n, r_done && (r_rsp.status == eida_pkg::ST_FULL), r_count == CW'(ENTITY_SLOTS), "full reported below capacity")
    `EIDA_ASSERT_SAME(a_full_id, i_clk, i_rst_n, r_done && (r_rsp.status == eida_pkg::ST_FULL), r_rsp.entity_out == '0, "full result carries an ID")

endmodule

`default_nettype wire

>>> hdl/entity_id_allocator_with_signatures_unit.sv
// Channel   | Handshake          | Word
// ----------+--------------------+-----------------------------------------
// request   | start, busy        | i_req (func, entity_id, signature_in)
// result    | o_done (strobe)    | o_rsp (status, entity_out, signature_out,
//           |                    |        living_count)
//
// A request is taken when start is high and busy low; the request word and
// the table read are registered, the request executes in S_EXEC with the
// registered read data and the write-back, and its result is registered onto
// o_rsp with o_done; a new request can be taken while o_done is high.
// After reset busy stays high while all ENTITY_SLOTS entries of the signature
// memory are swept to zero, one entry a cycle.
// The receiver cannot stall: each result is valid for its one strobe cycle.
// Top level of the entity ID allocator; depends on eida_pkg, eida_ctrl, eida_dp.
`default_nettype none

module entity_id_allocator_with_signatures_unit #(
    parameter int ENTITY_SLOTS   = eida_pkg::ENTITY_SLOTS_DEF,
    parameter int SIGNATURE_BITS = eida_pkg::SIGNATURE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire eida_pkg::t_req i_req,
    output eida_pkg::t_rsp      o_rsp,
    output logic                o_done
);

    eida_pkg::t_dp_cmd  cmd;
    eida_pkg::t_dp_stat stat;

    // Sequence the clearing pass and each request
    eida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Queue, table and result registers
    eida_dp #(
        .ENTITY_SLOTS   (ENTITY_SLOTS),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_stat  (stat),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule

`default_nettype wire
